// ===== hw/rtl/fdes_pkg.sv =====
// ----------------------------------------------------------------------------
// FAT directory entry search package
// Result codes, register indexes, character constants and the case fold
// shared by the directory entry search logic.
// ----------------------------------------------------------------------------
package fdes_pkg;

  // Result status codes.
  localparam logic [1:0] STATUS_FOUND     = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_TOO_LARGE = 2'd2;

  // Configuration register indexes (byte address is eight times the index).
  localparam logic [1:0] REG_TARGET_LOW  = 2'd0;
  localparam logic [1:0] REG_TARGET_HIGH = 2'd1;
  localparam logic [1:0] REG_TARGET_LEN  = 2'd2;
  localparam logic [1:0] REG_SIZE_LIMIT  = 2'd3;

  // Directory entry marks and attribute bits.
  localparam logic [7:0] NAME_DELETED  = 8'hE5;
  localparam logic [7:0] NAME_END      = 8'h00;
  localparam logic [7:0] ATTR_LONGNAME = 8'h0F;
  localparam logic [7:0] ATTR_DIR      = 8'h10;
  localparam logic [7:0] ATTR_VOLUME   = 8'h08;

  // Characters used when building the 8.3 name.
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_DOT     = 8'h2E;
  localparam logic [7:0] CHAR_NUL     = 8'h00;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  // Name geometry.
  localparam int NAME_CHARS   = 12;
  localparam int BASE_CHARS   = 8;
  localparam int EXT_CHARS    = 3;
  localparam logic [3:0] MAX_TARGET_LEN = 4'd12;

  // One result beat.
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] start_cluster;
    logic [31:0] found_size;
  } result_t;

  // Fold a..z to A..Z; every other byte passes unchanged.
  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      r = c - CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/fat_directory_entry_search.sv =====
// ----------------------------------------------------------------------------
// FAT directory entry search
// Scans FAT32 directory entries for a configured 8.3 file name and reports
// found, not found or too large once per search.
// ----------------------------------------------------------------------------
// Usage:
// Directory entries enter on the entry channel (entry_valid / entry_stall),
// one beat per entry. A beat with first_entry set starts a new search.
// Each search ends with exactly one beat on the result channel
// (result_valid / result_stall): found with cluster and size, not found on
// an end marker or after ENTRIES_PER_SECTOR examined entries, or too large.
// Beats that arrive while no search is active give no result.
// An entry's result, if any, is registered in the result register or the skid
// register. Every entry is decided by combinational name-building and compare
// logic, so throughput is one entry per cycle while entry_stall is low. A
// result that waits on a stalled receiver sits in the result register and one
// more result can be held in the skid register; entry_stall rises only while
// that skid register is full. The target name, its length and the size limit
// are written over the APB port at byte addresses 0, 8, 16 and 24; the user
// must write them only while the block is idle, which it does not enforce.
// Reset (rst, synchronous) clears the registers, empties both result
// registers and leaves no search active.
// ----------------------------------------------------------------------------
module fat_directory_entry_search #(
  parameter int ENTRIES_PER_SECTOR = 16
) (
  input  logic        clk,
  input  logic        rst,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  // Entry channel
  input  logic        entry_valid,
  output logic        entry_stall,
  input  logic        first_entry,
  input  logic [63:0] entry_name,
  input  logic [23:0] entry_ext,
  input  logic [7:0]  entry_attr,
  input  logic [15:0] cluster_high,
  input  logic [15:0] cluster_low,
  input  logic [31:0] entry_size,
  // Result channel
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  status,
  output logic [31:0] start_cluster,
  output logic [31:0] found_size
);

  import fdes_pkg::*;

  localparam int CNT_W = $clog2(ENTRIES_PER_SECTOR + 1);
  localparam logic [CNT_W-1:0] SECTOR_ENTRIES = CNT_W'(ENTRIES_PER_SECTOR);

  // Configuration registers.
  logic [63:0] target_chars_low;
  logic [31:0] target_chars_high;
  logic [3:0]  target_length;
  logic [31:0] size_limit;

  // Search state.
  logic             search_done;
  logic             search_done_next;
  logic [CNT_W-1:0] entries_seen;
  logic [CNT_W-1:0] entries_seen_next;

  // Result register and skid register.
  result_t out_data;
  result_t skid_data;
  logic    skid_valid;

  logic    cfg_write;
  logic    accept;
  logic    take;
  logic    has_result;
  result_t new_result;
  logic    name_match;

  assign pready      = 1'b1;
  assign cfg_write   = psel && penable && pwrite && pready;
  assign entry_stall = skid_valid;
  assign accept      = entry_valid && !entry_stall;
  assign take        = result_valid && !result_stall;

  assign status        = out_data.status;
  assign start_cluster = out_data.start_cluster;
  assign found_size    = out_data.found_size;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      target_chars_low  <= '0;
      target_chars_high <= '0;
      target_length     <= '0;
      size_limit        <= '0;
    end else if (cfg_write) begin
      case (paddr[4:3])
        REG_TARGET_LOW:  target_chars_low  <= pwdata;
        REG_TARGET_HIGH: target_chars_high <= pwdata[31:0];
        REG_TARGET_LEN:  target_length     <= pwdata[3:0];
        REG_SIZE_LIMIT:  size_limit        <= pwdata[31:0];
        default:         target_chars_low  <= target_chars_low;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr[4:3])
      REG_TARGET_LOW:  prdata = target_chars_low;
      REG_TARGET_HIGH: prdata = {32'd0, target_chars_high};
      REG_TARGET_LEN:  prdata = {60'd0, target_length};
      REG_SIZE_LIMIT:  prdata = {32'd0, size_limit};
      default:         prdata = '0;
    endcase
  end

  // Build the upper-cased 8.3 name of the entry and compare it with the
  // target. Both sides are cut at their first NUL character.
  always_comb begin
    logic [7:0] built [NAME_CHARS];
    logic [7:0] tchar [NAME_CHARS];
    logic [3:0] base_len;
    logic [3:0] ext_len;
    logic       ext_present;
    logic [3:0] name_len;
    logic [3:0] name_cut;
    logic [3:0] lim;
    logic [3:0] target_cut;
    logic [3:0] ext_pos;
    logic       eq;

    // Base length runs up to the first space.
    base_len = 4'd8;
    for (int i = BASE_CHARS - 1; i >= 0; i--) begin
      if (entry_name[8*i +: 8] == CHAR_SPACE) begin
        base_len = 4'(i);
      end
    end

    ext_present = entry_ext[7:0] != CHAR_SPACE;
    ext_len = 4'd3;
    for (int i = EXT_CHARS - 1; i >= 0; i--) begin
      if (entry_ext[8*i +: 8] == CHAR_SPACE) begin
        ext_len = 4'(i);
      end
    end

    // Place base characters, the dot and extension characters.
    for (int i = 0; i < NAME_CHARS; i++) begin
      ext_pos  = 4'(i) - base_len - 4'd1;
      built[i] = CHAR_NUL;
      if (4'(i) < base_len) begin
        built[i] = fold_upper(entry_name[8*(i % BASE_CHARS) +: 8]);
      end else if (ext_present && 4'(i) == base_len) begin
        built[i] = CHAR_DOT;
      end else if (ext_present && ext_pos < ext_len) begin
        case (ext_pos[1:0])
          2'd0:    built[i] = fold_upper(entry_ext[7:0]);
          2'd1:    built[i] = fold_upper(entry_ext[15:8]);
          default: built[i] = fold_upper(entry_ext[23:16]);
        endcase
      end
    end

    name_len = base_len + (ext_present ? (4'd1 + ext_len) : 4'd0);
    name_cut = name_len;
    for (int i = NAME_CHARS - 1; i >= 0; i--) begin
      if (4'(i) < name_len && built[i] == CHAR_NUL) begin
        name_cut = 4'(i);
      end
    end

    // Target characters and effective length.
    for (int i = 0; i < NAME_CHARS; i++) begin
      if (i < BASE_CHARS) begin
        tchar[i] = target_chars_low[8*(i % BASE_CHARS) +: 8];
      end else begin
        tchar[i] = target_chars_high[8*(i % 4) +: 8];
      end
    end
    lim = (target_length > MAX_TARGET_LEN) ? MAX_TARGET_LEN : target_length;
    target_cut = lim;
    for (int i = NAME_CHARS - 1; i >= 0; i--) begin
      if (4'(i) < lim && tchar[i] == CHAR_NUL) begin
        target_cut = 4'(i);
      end
    end

    eq = name_cut == target_cut;
    for (int i = 0; i < NAME_CHARS; i++) begin
      if (4'(i) < name_cut && fold_upper(tchar[i]) != built[i]) begin
        eq = 1'b0;
      end
    end
    name_match = eq;
  end

  // Search decision for the entry on the input.
  always_comb begin
    logic             active;
    logic [CNT_W-1:0] count;
    logic             skip;

    active = first_entry || !search_done;
    count  = first_entry ? '0 : entries_seen;
    skip   = entry_name[7:0] == NAME_DELETED || entry_attr == ATTR_LONGNAME ||
             (entry_attr & ATTR_DIR) != 8'd0 || (entry_attr & ATTR_VOLUME) != 8'd0;

    search_done_next         = !active;
    entries_seen_next        = count;
    has_result               = 1'b0;
    new_result.status        = STATUS_NOT_FOUND;
    new_result.start_cluster = '0;
    new_result.found_size    = '0;

    if (active) begin
      if (entry_name[7:0] == NAME_END) begin
        search_done_next = 1'b1;
        has_result       = 1'b1;
      end else begin
        if (count < SECTOR_ENTRIES) begin
          entries_seen_next = count + CNT_W'(1);
        end
        if (!skip && name_match) begin
          search_done_next      = 1'b1;
          has_result            = 1'b1;
          new_result.found_size = entry_size;
          if (entry_size > size_limit) begin
            new_result.status = STATUS_TOO_LARGE;
          end else begin
            new_result.status        = STATUS_FOUND;
            new_result.start_cluster = {cluster_high, cluster_low};
          end
        end else if (entries_seen_next >= SECTOR_ENTRIES) begin
          search_done_next = 1'b1;
          has_result       = 1'b1;
        end
      end
    end
  end

  // Search state update on each accepted entry beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      search_done  <= 1'b1;
      entries_seen <= '0;
    end else if (accept) begin
      search_done  <= search_done_next;
      entries_seen <= entries_seen_next;
    end
  end

  // Result register with a skid register behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (accept && has_result) begin
      if (!result_valid || take) begin
        result_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        out_data <= skid_data;
      end
    end else if (accept && has_result) begin
      if (!result_valid || take) begin
        out_data <= new_result;
      end else begin
        skid_data <= new_result;
      end
    end
  end

endmodule
